FILE: design/uart_register_block_unit_assert.svh
// Assertion macros for the serial interface register block.
`ifndef UART_REGISTER_BLOCK_UNIT_ASSERT_SVH
`define UART_REGISTER_BLOCK_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define URB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urb assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define URB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urb assertion failed");

`endif

FILE: design/urb_pkg.sv
// Package: transaction types, command and register codes, bit positions.
package urb_pkg;

  typedef struct packed {
    logic [2:0] cmd;
    logic [2:0] addr;
    logic [7:0] wdata;
    logic [7:0] rx_byte;
  } urb_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rx_accepted;
    logic       rx_ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       txi_pulse;
    logic       rxi_pulse;
    logic       eri_level;
    logic       tei_level;
  } urb_rsp_t;

  localparam logic [2:0] CMD_READ  = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_RX    = 3'd2;
  localparam logic [2:0] CMD_BREAK = 3'd3;
  localparam logic [2:0] CMD_TICK  = 3'd4;

  localparam logic [2:0] ADDR_SMR  = 3'd0;
  localparam logic [2:0] ADDR_BRR  = 3'd1;
  localparam logic [2:0] ADDR_SCR  = 3'd2;
  localparam logic [2:0] ADDR_TDR  = 3'd3;
  localparam logic [2:0] ADDR_SSR  = 3'd4;
  localparam logic [2:0] ADDR_RDR  = 3'd5;
  localparam logic [2:0] ADDR_SCMR = 3'd6;
  localparam logic [2:0] ADDR_SEMR = 3'd7;

  localparam int ST_MPBT = 0;
  localparam int ST_TEND = 2;
  localparam int ST_PER  = 3;
  localparam int ST_FER  = 4;
  localparam int ST_ORER = 5;
  localparam int ST_RDRF = 6;
  localparam int ST_TDRE = 7;
  localparam logic [7:0] ST_ERR_MASK = 8'h38;
  localparam logic [7:0] SSR_WR_MASK = 8'h39;

  localparam int CT_TEIE = 2;
  localparam int CT_RE   = 4;
  localparam int CT_TE   = 5;
  localparam int CT_RIE  = 6;
  localparam int CT_TIE  = 7;

  localparam int MD_STOP = 3;
  localparam int MD_PE   = 4;
  localparam int MD_CHR  = 6;

  localparam int CNT_W = 23;

  localparam logic [7:0] SMR_RST = 8'h00;
  localparam logic [7:0] BRR_RST = 8'hff;
  localparam logic [7:0] TDR_RST = 8'hff;
  localparam logic [7:0] SSR_RST = 8'h84;

endpackage

FILE: design/uart_register_block_unit.sv
// Top level: request register, register block core, response register.
//
// Serial interface register block. One request channel (req_valid, req_stall,
// req) carries bus reads and writes of the eight byte registers, bytes arriving
// from the serial line, line breaks and input-clock ticks. One response channel
// (rsp_valid, rsp_stall, rsp) returns exactly one response transaction for
// every request transaction, in order.
// Path: a request passes through the request register, the register block core
// and the response register, in that order, before its response appears.
// Throughput: one transaction per cycle while the receiver does not stall; the
// whole register update, including the frame-time multiply, is combinational
// between the request and response registers.
// Reset: registers take their documented values (SSR 0x84, BRR and TDR 0xff,
// the rest zero), countdowns clear, both channels go empty.
// Stall: when rsp_stall holds the response register full, the request register
// stays loaded and req_stall rises once it is full; no transaction is dropped.
module uart_register_block_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  urb_pkg::urb_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output urb_pkg::urb_rsp_t rsp
);
  import urb_pkg::*;

  logic     req_full;
  urb_req_t req_hold;
  urb_rsp_t core_res;
  logic     rsp_free, step;

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign step      = req_full && rsp_free;
  assign req_stall = req_full && !rsp_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_full <= 1'b0;
    end else if (!req_stall) begin
      req_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      req_hold <= req;
    end
  end

  urb_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (req_hold),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp <= core_res;
    end
  end

endmodule

FILE: design/urb_core.sv
// Register file, frame countdowns and single-pass next-state logic.
module urb_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  urb_pkg::urb_req_t req,
  output urb_pkg::urb_rsp_t res
);
  import urb_pkg::*;

  logic [7:0]       mode_reg, baud_reg, control_reg, transmit_reg, status_reg;
  logic [7:0]       receive_reg, smartcard_mode_reg, extended_mode_reg, status_snapshot;
  logic [CNT_W-1:0] tx_countdown, rx_countdown;
  logic             tx_running, error_irq, tx_end_irq;

  logic [7:0]       mode_reg_next, baud_reg_next, control_reg_next, transmit_reg_next;
  logic [7:0]       status_reg_next, receive_reg_next, smartcard_mode_reg_next;
  logic [7:0]       extended_mode_reg_next, status_snapshot_next;
  logic [CNT_W-1:0] tx_countdown_next, rx_countdown_next;
  logic             tx_running_next, error_irq_next, tx_end_irq_next;

  logic [3:0]       frame_bits;
  logic [11:0]      frame_prod;
  logic [2:0]       frame_shift;
  logic [CNT_W-1:0] frame_ticks;
  logic [CNT_W-1:0] tx_cnt_dec;
  logic             busy, start, frame_done;

  // frame time from the current mode and baud registers
  always_comb begin
    frame_bits  = 4'd9 - {3'b0, mode_reg[MD_CHR]} + {3'b0, mode_reg[MD_PE]}
                + {3'b0, mode_reg[MD_STOP]};
    frame_prod  = 12'(frame_bits) * 12'(baud_reg);
    frame_shift = {mode_reg[1:0], 1'b0};
    frame_ticks = (CNT_W'(frame_prod) << 5) << frame_shift;
  end

  assign busy       = control_reg[CT_TE] | control_reg[CT_RE];
  assign tx_cnt_dec = (tx_countdown != '0) ? tx_countdown - 1'b1 : tx_countdown;
  assign frame_done = (req.cmd == CMD_TICK) && tx_running && (tx_cnt_dec == '0);

  always_comb begin
    mode_reg_next           = mode_reg;
    baud_reg_next           = baud_reg;
    control_reg_next        = control_reg;
    transmit_reg_next       = transmit_reg;
    status_reg_next         = status_reg;
    receive_reg_next        = receive_reg;
    smartcard_mode_reg_next = smartcard_mode_reg;
    extended_mode_reg_next  = extended_mode_reg;
    status_snapshot_next    = status_snapshot;
    tx_countdown_next       = tx_countdown;
    rx_countdown_next       = rx_countdown;
    tx_running_next         = tx_running;
    error_irq_next          = error_irq;
    tx_end_irq_next         = tx_end_irq;
    start                   = 1'b0;
    res                     = '0;

    case (req.cmd)
      CMD_READ: begin
        unique case (req.addr)
          ADDR_SMR:  res.read_data = mode_reg;
          ADDR_BRR:  res.read_data = baud_reg;
          ADDR_SCR:  res.read_data = control_reg;
          ADDR_TDR:  res.read_data = transmit_reg;
          ADDR_SSR: begin
            status_snapshot_next = status_reg;
            res.read_data        = status_reg;
          end
          ADDR_RDR: begin
            status_reg_next[ST_RDRF] = 1'b0;
            res.read_data            = receive_reg;
          end
          ADDR_SCMR: res.read_data = smartcard_mode_reg;
          default:   res.read_data = extended_mode_reg;
        endcase
      end
      CMD_WRITE: begin
        unique case (req.addr)
          ADDR_SMR: if (!busy) mode_reg_next = req.wdata;
          ADDR_BRR: if (!busy) baud_reg_next = req.wdata;
          ADDR_SCR: begin
            control_reg_next = req.wdata;
            if (req.wdata[CT_TE]) begin
              status_reg_next[ST_TDRE] = 1'b1;
              status_reg_next[ST_TEND] = 1'b1;
              res.txi_pulse            = req.wdata[CT_TIE];
            end
            if (!req.wdata[CT_TEIE]) tx_end_irq_next = 1'b0;
            if (!req.wdata[CT_RIE])  error_irq_next  = 1'b0;
          end
          ADDR_TDR: begin
            transmit_reg_next = req.wdata;
            if (status_reg[ST_TEND]) begin
              start = 1'b1;
            end else begin
              status_reg_next[ST_TDRE] = 1'b0;
            end
          end
          ADDR_SSR: begin
            status_reg_next = (status_reg & ~SSR_WR_MASK) | (req.wdata & SSR_WR_MASK);
            if (((status_snapshot & ST_ERR_MASK) != '0) &&
                ((req.wdata & ST_ERR_MASK) == '0)) begin
              error_irq_next = 1'b0;
            end
          end
          ADDR_RDR:  ;
          ADDR_SCMR: smartcard_mode_reg_next = req.wdata;
          default:   extended_mode_reg_next  = req.wdata;
        endcase
      end
      CMD_RX: begin
        if (control_reg[CT_RE] && (rx_countdown == '0)) begin
          res.rx_accepted   = 1'b1;
          rx_countdown_next = frame_ticks;
          if (status_reg[ST_RDRF]) begin
            status_reg_next[ST_ORER] = 1'b1;
            if (control_reg[CT_RIE]) error_irq_next = 1'b1;
          end else begin
            receive_reg_next         = req.rx_byte;
            status_reg_next[ST_RDRF] = 1'b1;
            res.rxi_pulse            = control_reg[CT_RIE];
          end
        end
      end
      CMD_BREAK: begin
        status_reg_next[ST_FER] = 1'b1;
        if (control_reg[CT_RIE]) error_irq_next = 1'b1;
      end
      CMD_TICK: begin
        if (rx_countdown != '0) rx_countdown_next = rx_countdown - 1'b1;
        if (tx_running) tx_countdown_next = tx_cnt_dec;
        if (frame_done) begin
          if (!status_reg[ST_TDRE]) begin
            start = 1'b1;
          end else begin
            tx_running_next          = 1'b0;
            status_reg_next[ST_TEND] = 1'b1;
            if (control_reg[CT_TEIE]) tx_end_irq_next = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (start) begin
      res.tx_valid             = 1'b1;
      res.tx_byte              = transmit_reg_next;
      tx_running_next          = 1'b1;
      tx_countdown_next        = frame_ticks;
      status_reg_next[ST_TEND] = 1'b0;
      status_reg_next[ST_TDRE] = 1'b1;
      tx_end_irq_next          = 1'b0;
      if (control_reg[CT_TIE]) res.txi_pulse = 1'b1;
    end

    res.rx_ready  = control_reg_next[CT_RE] && (rx_countdown_next == '0);
    res.eri_level = error_irq_next;
    res.tei_level = tx_end_irq_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg           <= SMR_RST;
      baud_reg           <= BRR_RST;
      control_reg        <= '0;
      transmit_reg       <= TDR_RST;
      status_reg         <= SSR_RST;
      receive_reg        <= '0;
      smartcard_mode_reg <= '0;
      extended_mode_reg  <= '0;
      status_snapshot    <= '0;
      tx_countdown       <= '0;
      rx_countdown       <= '0;
      tx_running         <= 1'b0;
      error_irq          <= 1'b0;
      tx_end_irq         <= 1'b0;
    end else if (step) begin
      mode_reg           <= mode_reg_next;
      baud_reg           <= baud_reg_next;
      control_reg        <= control_reg_next;
      transmit_reg       <= transmit_reg_next;
      status_reg         <= status_reg_next;
      receive_reg        <= receive_reg_next;
      smartcard_mode_reg <= smartcard_mode_reg_next;
      extended_mode_reg  <= extended_mode_reg_next;
      status_snapshot    <= status_snapshot_next;
      tx_countdown       <= tx_countdown_next;
      rx_countdown       <= rx_countdown_next;
      tx_running         <= tx_running_next;
      error_irq          <= error_irq_next;
      tx_end_irq         <= tx_end_irq_next;
    end
  end

`include "uart_register_block_unit_assert.svh"

  `URB_ASSERT_NOW(a_tend_idle, !status_reg[ST_TEND], tx_running)
  `URB_ASSERT_NEXT(a_start_runs, step && res.tx_valid, tx_running && !status_reg[ST_TEND])
  `URB_ASSERT_NOW(a_eri_rie, $rose(error_irq), control_reg[CT_RIE])

endmodule

FILE: tb/serial_regs_checker.sv
// Checker for the serial register block: predicts each response and compares it.
`timescale 1ns / 1ps

module serial_regs_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  urb_pkg::urb_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  urb_pkg::urb_rsp_t rsp,
  output int                failures,
  output int                pending
);
  import urb_pkg::*;

  logic [7:0]       smr, brr, scr, tdr, ssr, rdr, scmr, semr, ssr_seen;
  logic [CNT_W-1:0] tx_left, rx_left;
  logic             tx_busy, err_line, tend_line;

  urb_rsp_t         awaited[$];
  int               errors;

  function automatic logic [CNT_W-1:0] frame_len();
    logic [31:0] n;
    n = 32'd8 - smr[MD_CHR] + smr[MD_PE] + smr[MD_STOP] + 32'd1;
    n = n * 32'd32 * brr;
    n = n << (2 * smr[1:0]);
    return n[CNT_W-1:0];
  endfunction

  function automatic void launch_byte(inout urb_rsp_t r);
    r.tx_valid = 1'b1;
    r.tx_byte = tdr;
    tx_busy = 1'b1;
    tx_left = frame_len();
    ssr[ST_TEND] = 1'b0;
    ssr[ST_TDRE] = 1'b1;
    tend_line = 1'b0;
    if (scr[CT_TIE]) r.txi_pulse = 1'b1;
  endfunction

  function automatic urb_rsp_t serial_step(urb_req_t t);
    urb_rsp_t r;
    r = '0;
    case (t.cmd)
      CMD_READ: begin
        case (t.addr)
          ADDR_SMR:  r.read_data = smr;
          ADDR_BRR:  r.read_data = brr;
          ADDR_SCR:  r.read_data = scr;
          ADDR_TDR:  r.read_data = tdr;
          ADDR_SSR: begin
            ssr_seen = ssr;
            r.read_data = ssr;
          end
          ADDR_RDR: begin
            ssr[ST_RDRF] = 1'b0;
            r.read_data = rdr;
          end
          ADDR_SCMR: r.read_data = scmr;
          default:   r.read_data = semr;
        endcase
      end
      CMD_WRITE: begin
        case (t.addr)
          ADDR_SMR: if (!(scr[CT_TE] || scr[CT_RE])) smr = t.wdata;
          ADDR_BRR: if (!(scr[CT_TE] || scr[CT_RE])) brr = t.wdata;
          ADDR_SCR: begin
            scr = t.wdata;
            if (t.wdata[CT_TE]) begin
              ssr[ST_TDRE] = 1'b1;
              ssr[ST_TEND] = 1'b1;
              if (t.wdata[CT_TIE]) r.txi_pulse = 1'b1;
            end
            if (!t.wdata[CT_TEIE]) tend_line = 1'b0;
            if (!t.wdata[CT_RIE]) err_line = 1'b0;
          end
          ADDR_TDR: begin
            tdr = t.wdata;
            if (ssr[ST_TEND]) launch_byte(r);
            else ssr[ST_TDRE] = 1'b0;
          end
          ADDR_SSR: begin
            ssr = (ssr & ~SSR_WR_MASK) | (t.wdata & SSR_WR_MASK);
            if ((ssr_seen & ST_ERR_MASK) != 8'h00 && (ssr & ST_ERR_MASK) == 8'h00)
              err_line = 1'b0;
          end
          ADDR_RDR: ;
          ADDR_SCMR: scmr = t.wdata;
          default:   semr = t.wdata;
        endcase
      end
      CMD_RX: begin
        if (scr[CT_RE] && rx_left == '0) begin
          r.rx_accepted = 1'b1;
          rx_left = frame_len();
          if (ssr[ST_RDRF]) begin
            ssr[ST_ORER] = 1'b1;
            if (scr[CT_RIE]) err_line = 1'b1;
          end else begin
            rdr = t.rx_byte;
            ssr[ST_RDRF] = 1'b1;
            if (scr[CT_RIE]) r.rxi_pulse = 1'b1;
          end
        end
      end
      CMD_BREAK: begin
        ssr[ST_FER] = 1'b1;
        if (scr[CT_RIE]) err_line = 1'b1;
      end
      CMD_TICK: begin
        if (rx_left != '0) rx_left = rx_left - 1'b1;
        if (tx_busy) begin
          if (tx_left != '0) tx_left = tx_left - 1'b1;
          if (tx_left == '0) begin
            if (!ssr[ST_TDRE]) begin
              launch_byte(r);
            end else begin
              tx_busy = 1'b0;
              ssr[ST_TEND] = 1'b1;
              if (scr[CT_TEIE]) tend_line = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.rx_ready = scr[CT_RE] && rx_left == '0;
    r.eri_level = err_line;
    r.tei_level = tend_line;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %02h, got %02h", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    urb_rsp_t want;
    if (rst) begin
      smr = SMR_RST;
      brr = BRR_RST;
      scr = 8'h00;
      tdr = TDR_RST;
      ssr = SSR_RST;
      rdr = 8'h00;
      scmr = 8'h00;
      semr = 8'h00;
      ssr_seen = 8'h00;
      tx_left = '0;
      rx_left = '0;
      tx_busy = 1'b0;
      err_line = 1'b0;
      tend_line = 1'b0;
      awaited.delete();
    end else begin
      if (req_valid && !req_stall) awaited.push_back(serial_step(req));
      if (rsp_valid && !rsp_stall) begin
        if (awaited.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected response transaction %h", rsp);
        end else begin
          want = awaited.pop_front();
          check_field("read_data", rsp.read_data, want.read_data);
          check_field("rx_accepted", 8'(rsp.rx_accepted), 8'(want.rx_accepted));
          check_field("rx_ready", 8'(rsp.rx_ready), 8'(want.rx_ready));
          check_field("tx_valid", 8'(rsp.tx_valid), 8'(want.tx_valid));
          check_field("tx_byte", rsp.tx_byte, want.tx_byte);
          check_field("txi_pulse", 8'(rsp.txi_pulse), 8'(want.txi_pulse));
          check_field("rxi_pulse", 8'(rsp.rxi_pulse), 8'(want.rxi_pulse));
          check_field("eri_level", 8'(rsp.eri_level), 8'(want.eri_level));
          check_field("tei_level", 8'(rsp.tei_level), 8'(want.tei_level));
        end
      end
    end
    pending <= awaited.size();
    failures <= errors;
  end

  initial begin
    errors = 0;
  end

endmodule

FILE: tb/testbench.sv
// Top of the testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 1ps

module testbench;
  import urb_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 60;
  localparam logic [7:0] SCR_ALL = 8'((1 << CT_TIE) | (1 << CT_RIE) | (1 << CT_TE) |
                                      (1 << CT_RE) | (1 << CT_TEIE));

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  urb_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  urb_rsp_t rsp;
  int       failures;
  int       pending;

  int       sent;

  uart_register_block_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  serial_regs_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send(input logic [2:0] c, input logic [2:0] a, input logic [7:0] w,
                      input logic [7:0] b);
    urb_req_t t;
    t.cmd = c;
    t.addr = a;
    t.wdata = w;
    t.rx_byte = b;
    while (!(sent >= 250 && sent < 400) && $urandom_range(99) < 13) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send(CMD_TICK, 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task automatic send_noise();
    int          pick;
    logic [2:0]  c;
    logic [2:0]  a;
    logic [7:0]  w;
    pick = $urandom_range(99);
    a = 3'($urandom);
    w = 8'($urandom);
    if (pick < 20)      c = CMD_READ;
    else if (pick < 45) c = CMD_WRITE;
    else if (pick < 60) c = CMD_RX;
    else if (pick < 68) c = CMD_BREAK;
    else if (pick < 92) c = CMD_TICK;
    else                c = 3'(CMD_TICK + $urandom_range(1, 3));
    // keep frames at zero length outside the long-frame runs
    if (c == CMD_WRITE && a == ADDR_BRR) w = 8'h00;
    send(c, a, w, 8'($urandom));
  endtask

  // receiver: random stall, one long hold-off, one stretch with no stall
  initial begin
    int cyc;
    rsp_stall <= 1'b0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 400) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      rsp_stall <= (cyc > 1200 && cyc < 1800) ? 1'b0 : ($urandom_range(99) < 13);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL uart_register_block_unit");
    $finish;
  end

  initial begin
    logic [7:0] w;
    logic [2:0] c;
    int         pick;
    int         seqs;
    int         n;
    sent = 0;
    seqs = 0;
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send(CMD_READ, ADDR_SMR, 8'($urandom), 8'($urandom));
    send(CMD_READ, ADDR_SSR, 8'($urandom), 8'($urandom));
    send(CMD_WRITE, ADDR_SMR, 8'hff, 8'($urandom));
    send(CMD_WRITE, ADDR_BRR, 8'hff, 8'($urandom));
    send(CMD_READ, ADDR_BRR, 8'($urandom), 8'($urandom));
    send(CMD_WRITE, ADDR_TDR, 8'ha5, 8'($urandom));
    send(CMD_WRITE, ADDR_TDR, 8'h5a, 8'($urandom));
    send_ticks(1);
    send(CMD_WRITE, ADDR_SCR, SCR_ALL, 8'($urandom));
    send(CMD_WRITE, ADDR_SMR, 8'h00, 8'($urandom));
    send(CMD_READ, ADDR_SMR, 8'($urandom), 8'($urandom));
    send(CMD_WRITE, ADDR_SCR, 8'h00, 8'($urandom));
    send(CMD_RX, ADDR_RDR, 8'($urandom), 8'h11);
    send(CMD_WRITE, ADDR_SMR, 8'h00, 8'($urandom));
    send(CMD_WRITE, ADDR_BRR, 8'h00, 8'($urandom));
    send(CMD_WRITE, ADDR_SCR, SCR_ALL, 8'($urandom));
    send(CMD_WRITE, ADDR_TDR, 8'h00, 8'($urandom));
    send(CMD_WRITE, ADDR_TDR, 8'hff, 8'($urandom));
    send_ticks(2);
    send(CMD_RX, ADDR_SMR, 8'($urandom), 8'h3c);
    send(CMD_RX, ADDR_SMR, 8'($urandom), 8'hc3);
    send(CMD_BREAK, ADDR_SMR, 8'($urandom), 8'($urandom));
    send(CMD_READ, ADDR_SSR, 8'($urandom), 8'($urandom));
    send(CMD_WRITE, ADDR_SSR, 8'hff, 8'($urandom));
    send(CMD_WRITE, ADDR_SSR, 8'h00, 8'($urandom));
    send(CMD_WRITE, ADDR_RDR, 8'h77, 8'($urandom));
    send(CMD_READ, ADDR_RDR, 8'($urandom), 8'($urandom));
    send(CMD_WRITE, ADDR_SCMR, 8'hff, 8'($urandom));
    send(CMD_WRITE, ADDR_SEMR, 8'h5a, 8'($urandom));
    send(CMD_READ, ADDR_SCMR, 8'($urandom), 8'($urandom));
    send(CMD_READ, ADDR_SEMR, 8'($urandom), 8'($urandom));
    c = CMD_TICK;
    repeat (3) begin
      c++;
      send(c, 3'($urandom), 8'($urandom), 8'($urandom));
    end

    while (sent < 600) begin
      seqs++;
      pick = $urandom_range(99);
      if (seqs == 30) begin
        // long frame: nonzero countdowns on both directions
        w = 8'($urandom);
        w[CT_TE] = 1'b0;
        w[CT_RE] = 1'b0;
        send(CMD_WRITE, ADDR_SCR, w, 8'($urandom));
        send(CMD_WRITE, ADDR_SMR, 8'($urandom) & 8'hfc, 8'($urandom));
        send(CMD_WRITE, ADDR_BRR, 8'h01, 8'($urandom));
        w = 8'($urandom);
        w[CT_TE] = 1'b1;
        w[CT_RE] = 1'b1;
        send(CMD_WRITE, ADDR_SCR, w, 8'($urandom));
        send(CMD_WRITE, ADDR_TDR, 8'($urandom), 8'($urandom));
        send(CMD_WRITE, ADDR_TDR, 8'($urandom), 8'($urandom));
        send(CMD_RX, 3'($urandom), 8'($urandom), 8'($urandom));
        send_ticks(1);
        send(CMD_RX, 3'($urandom), 8'($urandom), 8'($urandom));
        n = $urandom_range(200, 400);
        send_ticks(n);
        w = 8'($urandom);
        w[CT_TE] = 1'b0;
        w[CT_RE] = 1'b0;
        send(CMD_WRITE, ADDR_SCR, w, 8'($urandom));
        send(CMD_WRITE, ADDR_BRR, 8'h00, 8'($urandom));
      end else if (pick < 30) begin
        send_noise();
      end else if (pick < 55) begin
        w = 8'($urandom);
        w[CT_TE] = 1'b1;
        send(CMD_WRITE, ADDR_SCR, w, 8'($urandom));
        repeat ($urandom_range(1, 3)) begin
          send(CMD_WRITE, ADDR_TDR, 8'($urandom), 8'($urandom));
          send_ticks($urandom_range(0, 3));
        end
        send(CMD_READ, ADDR_SSR, 8'($urandom), 8'($urandom));
      end else if (pick < 75) begin
        w = 8'($urandom);
        w[CT_RE] = 1'b1;
        send(CMD_WRITE, ADDR_SCR, w, 8'($urandom));
        repeat ($urandom_range(1, 3)) begin
          send(CMD_RX, 3'($urandom), 8'($urandom), 8'($urandom));
          send_ticks($urandom_range(0, 1));
        end
        send(CMD_READ, ADDR_SSR, 8'($urandom), 8'($urandom));
        if ($urandom_range(1) == 1)
          send(CMD_WRITE, ADDR_SSR, 8'($urandom), 8'($urandom));
        send(CMD_READ, ADDR_RDR, 8'($urandom), 8'($urandom));
      end else if (pick < 87) begin
        send_ticks($urandom_range(1, 10));
      end else begin
        send(CMD_BREAK, 3'($urandom), 8'($urandom), 8'($urandom));
        send(CMD_READ, ADDR_SSR, 8'($urandom), 8'($urandom));
        w = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom);
        send(CMD_WRITE, ADDR_SSR, w, 8'($urandom));
      end
    end

    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("PASS uart_register_block_unit");
    end else begin
      $display("FAIL uart_register_block_unit");
    end
    $finish;
  end

endmodule
